>>> rtl/aed_pkg.sv
// ----------------------------------------------------------------------------
// aed_pkg: shared types and constants of the audio envelope detector
// Widths, register and mode codes, configuration struct, sequencer states.
// ----------------------------------------------------------------------------
package aed_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEFF_BITS  = 16;
   localparam int ENV_BITS    = 32;
   localparam int LEVEL_BITS  = 33;
   localparam int ADDR_BITS   = 5;

   // 20*log10(2) in Q.24
   localparam logic [26:0] DB_LOG2_K = 27'd101008905;
   // -96 dB in Q8.8
   localparam logic [LEVEL_BITS-1:0] DB_FLOOR_Q88 = -33'sd24576;
   localparam logic [ENV_BITS:0] UNITY_Q31 = 33'h0_8000_0000;

   localparam logic [1:0] MODE_PEAK = 2'd0;
   localparam logic [1:0] MODE_MS   = 2'd1;
   localparam logic [1:0] MODE_RMS  = 2'd2;

   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_RELEASE = 3'd1;
   localparam logic [2:0] REG_MODE    = 3'd2;
   localparam logic [2:0] REG_CLAMP   = 3'd3;
   localparam logic [2:0] REG_DB      = 3'd4;

   typedef struct packed {
      logic [COEFF_BITS-1:0] attack_coeff;
      logic [COEFF_BITS-1:0] release_coeff;
      logic [1:0]            detect_mode;
      logic                  clamp_to_unity;
      logic                  output_db;
   } aed_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV,
      ST_SQRT,
      ST_POST,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_MUL,
      ST_RND,
      ST_OUT
   } aed_state_type;

endpackage

>>> rtl/aed_front.sv
// ----------------------------------------------------------------------------
// aed_front: register file and sample conditioning
// Holds the configuration registers and turns each sample into the Q1.31
// detector input (magnitude or squared magnitude).
// ----------------------------------------------------------------------------
module aed_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [aed_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [aed_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic [aed_pkg::ENV_BITS-1:0]          q_data,
   output aed_pkg::aed_cfg_type                  cfg
);

   localparam int SB = aed_pkg::SAMPLE_BITS;
   localparam int SQ_SHIFT = 2 * (SB - 1);

   aed_pkg::aed_cfg_type cfg_ff, cfg_in;
   logic [2:0]      reg_idx;
   logic            wr_en;
   logic [SB-1:0]   raw;
   logic [SB-1:0]   mag;
   logic [2*SB-1:0] sq;
   logic [63:0]     mag_wide;
   logic [63:0]     sq_wide;
   logic [63:0]     inp_wide;
   logic            squared;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            aed_pkg::REG_ATTACK:  cfg_in.attack_coeff   = pwdata[aed_pkg::COEFF_BITS-1:0];
            aed_pkg::REG_RELEASE: cfg_in.release_coeff  = pwdata[aed_pkg::COEFF_BITS-1:0];
            aed_pkg::REG_MODE:    cfg_in.detect_mode    = pwdata[1:0];
            aed_pkg::REG_CLAMP:   cfg_in.clamp_to_unity = pwdata[0];
            aed_pkg::REG_DB:      cfg_in.output_db      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // return register contents
   always_comb begin
      unique case (reg_idx)
         aed_pkg::REG_ATTACK:  prdata = 32'(cfg_ff.attack_coeff);
         aed_pkg::REG_RELEASE: prdata = 32'(cfg_ff.release_coeff);
         aed_pkg::REG_MODE:    prdata = 32'(cfg_ff.detect_mode);
         aed_pkg::REG_CLAMP:   prdata = 32'(cfg_ff.clamp_to_unity);
         aed_pkg::REG_DB:      prdata = 32'(cfg_ff.output_db);
         default:              prdata = 32'd0;
      endcase
   end

   // form magnitude, square it in the MS and RMS modes, scale to Q1.31
   assign raw      = req_sample;
   assign mag      = raw[SB-1] ? (~raw + 1'b1) : raw;
   assign mag_wide = 64'(mag);
   assign sq       = mag * mag;
   assign sq_wide  = 64'(sq);
   assign squared  = (cfg_ff.detect_mode == aed_pkg::MODE_MS) ||
                     (cfg_ff.detect_mode == aed_pkg::MODE_RMS);

   always_comb begin
      if (squared) begin
         if (SQ_SHIFT <= 31) begin
            inp_wide = sq_wide << (31 - SQ_SHIFT);
         end else begin
            inp_wide = sq_wide >> (SQ_SHIFT - 31);
         end
      end else begin
         inp_wide = mag_wide << (32 - SB);
      end
   end

   assign q_data    = inp_wide[aed_pkg::ENV_BITS-1:0];
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

>>> rtl/aed_queue.sv
// ----------------------------------------------------------------------------
// aed_queue: two-entry queue between front and back
// Decouples sample acceptance from the multi-cycle level computation.
// ----------------------------------------------------------------------------
module aed_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [aed_pkg::ENV_BITS-1:0]  push_data,
   input  logic                          pop,
   output logic [aed_pkg::ENV_BITS-1:0]  pop_data,
   output logic                          full,
   output logic                          empty
);

   logic [aed_pkg::ENV_BITS-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/aed_back.sv
// ----------------------------------------------------------------------------
// aed_back: envelope smoother, square root and decibel sequencer
// Updates the envelope, then runs the bit-serial square root, the normalize
// loop, the repeated-squaring log and the dB scaling, and holds the result.
// ----------------------------------------------------------------------------
module aed_back (
   input  logic                                clock,
   input  logic                                reset,
   input  aed_pkg::aed_cfg_type                cfg,
   input  logic                                q_empty,
   input  logic [aed_pkg::ENV_BITS-1:0]        q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [aed_pkg::LEVEL_BITS-1:0] rsp_level
);

   localparam int CB = aed_pkg::COEFF_BITS;
   localparam int EB = aed_pkg::ENV_BITS;
   localparam int LB = aed_pkg::LEVEL_BITS;

   aed_pkg::aed_state_type state_ff, state_in;

   logic [EB-1:0] inp_ff, inp_in;
   logic [EB-1:0] env_ff, env_in;
   logic [EB-1:0] lin_ff, lin_in;
   logic [63:0]   rad_ff, rad_in;
   logic [33:0]   rem_ff, rem_in;
   logic [EB-1:0] root_ff, root_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [EB-1:0] x_ff, x_in;
   logic [4:0]    n_ff, n_in;
   logic [23:0]   frac_ff, frac_in;
   logic [28:0]   m_ff, m_in;
   logic          neg_ff, neg_in;
   logic [55:0]   prod_ff, prod_in;
   logic [LB-1:0] res_ff, res_in;
   logic [LB-1:0] level_ff, level_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic              out_free;
   logic              env_ge;
   logic [CB-1:0]     coeff;
   logic [EB-1:0]     diff;
   logic [EB+CB-1:0]  dprod;
   logic [EB:0]       env_new;
   logic [33:0]       rem_try;
   logic [33:0]       trial;
   logic [63:0]       xsq;
   logic [56:0]       rnd_sum;
   logic [16:0]       rnd_mag;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // smoother arithmetic
   assign env_ge  = env_ff >= inp_ff;
   assign coeff   = env_ge ? cfg.release_coeff : cfg.attack_coeff;
   assign diff    = env_ge ? (env_ff - inp_ff) : (inp_ff - env_ff);
   assign dprod   = diff * coeff;
   assign env_new = env_ge ? ({1'b0, inp_ff} + {1'b0, dprod[EB+CB-1:CB]})
                           : ({1'b0, inp_ff} - {1'b0, dprod[EB+CB-1:CB]});

   // square root digit step and log squaring step
   assign rem_try = {rem_ff[31:0], rad_ff[63:62]};
   assign trial   = {root_ff, 2'b01};
   assign xsq     = x_ff * x_ff;
   assign rnd_sum = {1'b0, prod_ff} + 57'(64'h80_0000_0000);
   assign rnd_mag = rnd_sum[56:40];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aed_pkg::ST_IDLE:  if (!q_empty) state_in = aed_pkg::ST_ENV;
         aed_pkg::ST_ENV: begin
            if (cfg.detect_mode == aed_pkg::MODE_RMS) state_in = aed_pkg::ST_SQRT;
            else state_in = aed_pkg::ST_POST;
         end
         aed_pkg::ST_SQRT:  if (cnt_ff == 5'd0) state_in = aed_pkg::ST_POST;
         aed_pkg::ST_POST: begin
            if (cfg.output_db && lin_ff != '0) state_in = aed_pkg::ST_NORM;
            else state_in = aed_pkg::ST_OUT;
         end
         aed_pkg::ST_NORM:  if (x_ff[EB-1]) state_in = aed_pkg::ST_LOG;
         aed_pkg::ST_LOG:   if (cnt_ff == 5'd0) state_in = aed_pkg::ST_SCALE;
         aed_pkg::ST_SCALE: state_in = aed_pkg::ST_MUL;
         aed_pkg::ST_MUL:   state_in = aed_pkg::ST_RND;
         aed_pkg::ST_RND:   state_in = aed_pkg::ST_OUT;
         aed_pkg::ST_OUT:   if (out_free) state_in = aed_pkg::ST_IDLE;
         default:           state_in = aed_pkg::ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      inp_in       = inp_ff;
      env_in       = env_ff;
      lin_in       = lin_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      frac_in      = frac_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      unique case (state_ff)
         aed_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               inp_in = q_data;
            end
         end
         aed_pkg::ST_ENV: begin
            // clamp to unity if enabled
            if (cfg.clamp_to_unity && env_new > aed_pkg::UNITY_Q31) begin
               env_in = aed_pkg::UNITY_Q31[EB-1:0];
            end else begin
               env_in = env_new[EB-1:0];
            end
            lin_in  = env_in;
            rad_in  = {1'b0, env_in, 31'd0};
            rem_in  = '0;
            root_in = '0;
            cnt_in  = 5'd31;
         end
         aed_pkg::ST_SQRT: begin
            if (rem_try >= trial) begin
               rem_in  = rem_try - trial;
               root_in = {root_ff[EB-2:0], 1'b1};
            end else begin
               rem_in  = rem_try;
               root_in = {root_ff[EB-2:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 5'd1;
            lin_in = root_in;
         end
         aed_pkg::ST_POST: begin
            x_in = lin_ff;
            n_in = 5'd31;
            if (!cfg.output_db) res_in = LB'(lin_ff);
            else res_in = aed_pkg::DB_FLOOR_Q88;
         end
         aed_pkg::ST_NORM: begin
            if (!x_ff[EB-1]) begin
               x_in = {x_ff[EB-2:0], 1'b0};
               n_in = n_ff - 5'd1;
            end
            cnt_in  = 5'd23;
            frac_in = '0;
         end
         aed_pkg::ST_LOG: begin
            // one fraction bit of log2 per squaring
            if (xsq[63]) x_in = xsq[63:32];
            else x_in = xsq[62:31];
            frac_in = {frac_ff[22:0], xsq[63]};
            cnt_in  = cnt_ff - 5'd1;
         end
         aed_pkg::ST_SCALE: begin
            if (n_ff == 5'd31) begin
               m_in   = 29'(frac_ff);
               neg_in = 1'b0;
            end else begin
               m_in   = {5'd31 - n_ff, 24'd0} - 29'(frac_ff);
               neg_in = 1'b1;
            end
         end
         aed_pkg::ST_MUL: begin
            prod_in = m_ff * aed_pkg::DB_LOG2_K;
         end
         aed_pkg::ST_RND: begin
            if (neg_ff) res_in = LB'(0) - LB'(rnd_mag);
            else res_in = LB'(rnd_mag);
         end
         aed_pkg::ST_OUT: begin
            if (out_free) begin
               level_in     = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aed_pkg::ST_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inp_ff   <= inp_in;
      lin_ff   <= lin_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      n_ff     <= n_in;
      frac_ff  <= frac_in;
      m_ff     <= m_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      level_ff <= level_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_ff;

endmodule

>>> rtl/audio_envelope_detector_top.sv
// ----------------------------------------------------------------------------
// audio_envelope_detector_top: attack/release envelope follower
// Peak, mean-square and RMS detection with linear or dB level output.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+------------------------------
//   req      | req_valid/ready, req_sample    | one Q1.15 sample per transfer
//   rsp      | rsp_valid/ready, rsp_level     | one level per transfer
//   csr      | psel, penable, pwrite, paddr.. | register write or read
//
// A sample passes the idle, envelope, post and output states in linear peak/MS
// mode, plus the RMS square root (one bit per cycle), and plus the normalize
// loop, 24 squarings and the scale, multiply and round states for dB output.
// Synchronous reset clears envelope, registers and queue. Two samples queue
// up while the back end works or a result waits for rsp_ready.
// ----------------------------------------------------------------------------
module audio_envelope_detector_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [aed_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [aed_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [aed_pkg::LEVEL_BITS-1:0] rsp_level
);

   aed_pkg::aed_cfg_type cfg;
   logic                         q_full;
   logic                         q_empty;
   logic                         q_push;
   logic                         q_pop;
   logic [aed_pkg::ENV_BITS-1:0] q_wdata;
   logic [aed_pkg::ENV_BITS-1:0] q_rdata;

   // accept and condition samples
   aed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .cfg        (cfg)
   );

   // hold conditioned samples
   aed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   // smooth and compute the level
   aed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_level (rsp_level)
   );

endmodule
